@@ src/gskrf_pkg.sv @@
// Shared constants, types and helpers of the gated scalar Kalman range filter.
package gskrf_pkg;

   // Datapath widths
   localparam int NUM_W     = 56;               // gain numerator, sb * C
   localparam int DEN_W     = 48;               // gain denominator
   localparam int QUO_W     = 32;               // gain K, Q16.16
   localparam int DIV_CNT_W = $clog2(QUO_W);
   localparam int OP_W      = 4;

   // Multiply steps, in issue order
   localparam logic [OP_W-1:0] OP_AMU = 4'd0;   // A * estimate     -> predicted mean
   localparam logic [OP_W-1:0] OP_AA  = 4'd1;   // A * A
   localparam logic [OP_W-1:0] OP_SB  = 4'd2;   // A^2 * variance   -> predicted variance
   localparam logic [OP_W-1:0] OP_CC  = 4'd3;   // C * C
   localparam logic [OP_W-1:0] OP_DEN = 4'd4;   // C^2 * sb         -> gain denominator
   localparam logic [OP_W-1:0] OP_NUM = 4'd5;   // sb * C           -> gain numerator
   localparam logic [OP_W-1:0] OP_CMU = 4'd6;   // C * mean         -> innovation
   localparam logic [OP_W-1:0] OP_KI  = 4'd7;   // K * innovation   -> new estimate
   localparam logic [OP_W-1:0] OP_KC  = 4'd8;   // K * C            -> variance factor
   localparam logic [OP_W-1:0] OP_FSB = 4'd9;   // factor * sb      -> new variance
   localparam logic [OP_W-1:0] OP_OUT = 4'd10;  // estimate * scale -> result

   // Configuration register indexes
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic [CSR_IDX_W-1:0] CSR_STATE_GAIN     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MEASURE_GAIN   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PROCESS_NOISE  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_MEASURE_NOISE  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_GRADIENT_LIMIT = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_OUTPUT_SCALE   = 3'd5;

   // Configuration reset values
   localparam logic [23:0] RST_STATE_GAIN     = 24'd65536;
   localparam logic [23:0] RST_MEASURE_GAIN   = 24'd65536;
   localparam logic [31:0] RST_PROCESS_NOISE  = 32'd134218;
   localparam logic [31:0] RST_MEASURE_NOISE  = 32'd1418262;
   localparam logic [15:0] RST_GRADIENT_LIMIT = 16'd100;
   localparam logic [23:0] RST_OUTPUT_SCALE   = 24'd65536;

   localparam logic signed [50:0] SAT_HI = 51'sd2147483647;
   localparam logic signed [50:0] SAT_LO = -51'sd2147483648;

   // Controller to datapath
   typedef struct packed {
      logic            load_sample;
      logic            shift_hist;
      logic            mul_issue;
      logic            round_en;
      logic            write_en;
      logic            div_start;
      logic [OP_W-1:0] op;
   } gskrf_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic use_sample;
      logic div_done;
      logic out_free;
   } gskrf_stat_type;

   // Clamp to the signed 32-bit range
   function automatic logic signed [31:0] sat32(input logic signed [50:0] v);
      logic signed [31:0] r;
      if (v > SAT_HI) begin
         r = 32'sh7FFFFFFF;
      end else if (v < SAT_LO) begin
         r = 32'sh80000000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

endpackage

@@ src/gskrf_div.sv @@
// Restoring divider for the Kalman gain: signed numerator, unsigned denominator, one bit a cycle.
module gskrf_div import gskrf_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic signed [NUM_W-1:0] num,
   input  logic        [DEN_W-1:0] den,
   output logic                    done,
   output logic signed [QUO_W-1:0] quo
);

   localparam logic [DIV_CNT_W-1:0] CNT_LAST = DIV_CNT_W'(QUO_W - 1);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                 neg_ff, neg_in;
   logic                 zero_ff, zero_in;
   logic                 ovf_ff, ovf_in;
   logic [DEN_W-1:0]     rem_ff, rem_in;
   logic [QUO_W-1:0]     qsh_ff, qsh_in;

   logic [NUM_W-1:0]     mag;
   logic [DEN_W:0]       trial;
   logic [DEN_W:0]       diff;
   logic                 fits;

   // Magnitude of the numerator and one trial subtraction
   assign mag   = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
   assign trial = {rem_ff, qsh_ff[QUO_W-1]};
   assign fits  = trial >= {1'b0, den};
   assign diff  = trial - {1'b0, den};

   // Sequence the iterations
   always_comb begin
      busy_in = busy_ff;
      done_in = done_ff;
      cnt_in  = cnt_ff;
      neg_in  = neg_ff;
      zero_in = zero_ff;
      ovf_in  = ovf_ff;
      rem_in  = rem_ff;
      qsh_in  = qsh_ff;
      if (start) begin
         busy_in = 1'b1;
         done_in = 1'b0;
         cnt_in  = '0;
         neg_in  = num[NUM_W-1];
         zero_in = (den == '0);
         ovf_in  = DEN_W'(mag[NUM_W-1:QUO_W]) >= den;
         rem_in  = DEN_W'(mag[NUM_W-1:QUO_W]);
         qsh_in  = mag[QUO_W-1:0];
      end else if (busy_ff) begin
         if (zero_ff || ovf_ff) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            rem_in = fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
            qsh_in = {qsh_ff[QUO_W-2:0], fits};
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_LAST) begin
               busy_in = 1'b0;
               done_in = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      neg_ff  <= neg_in;
      zero_ff <= zero_in;
      ovf_ff  <= ovf_in;
      rem_ff  <= rem_in;
      qsh_ff  <= qsh_in;
   end

   // Apply sign, saturate; zero denominator gives zero gain
   always_comb begin
      if (zero_ff) begin
         quo = '0;
      end else if (ovf_ff || qsh_ff[QUO_W-1]) begin
         quo = neg_ff ? 32'sh80000000 : 32'sh7FFFFFFF;
      end else begin
         quo = neg_ff ? -$signed(qsh_ff) : $signed(qsh_ff);
      end
   end

   assign done = done_ff;

endmodule

@@ src/gskrf_dpath.sv @@
// Datapath: configuration, filter state, shared multiplier, rounding, write-back and output register.
module gskrf_dpath import gskrf_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  gskrf_cmd_type         cmd,
   output gskrf_stat_type        stat,
   input  logic signed [15:0]    req_range_sample,
   input  logic                  rsp_ready,
   output logic                  rsp_valid,
   output logic signed [31:0]    rsp_filtered_range,
   input  logic                  csr_write_enable,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   // Configuration
   logic signed [23:0] sg_ff, sg_in;
   logic signed [23:0] mg_ff, mg_in;
   logic [31:0]        pn_ff, pn_in;
   logic [31:0]        mn_ff, mn_in;
   logic [15:0]        gl_ff, gl_in;
   logic [23:0]        os_ff, os_in;

   // Filter state
   logic signed [15:0] sample_ff, sample_in;
   logic signed [15:0] last_ff, last_in;
   logic signed [15:0] prior_ff, prior_in;
   logic signed [31:0] est_ff, est_in;
   logic [31:0]        var_ff, var_in;

   // Intermediates of one update
   logic signed [31:0]       mub_ff, mub_in;
   logic [30:0]              a2_ff, a2_in;
   logic [31:0]              sb_ff, sb_in;
   logic [30:0]              c2_ff, c2_in;
   logic [DEN_W-1:0]         den_ff, den_in;
   logic signed [NUM_W-1:0]  num_ff, num_in;
   logic signed [31:0]       innov_ff, innov_in;
   logic [16:0]              f_ff, f_in;

   // Multiplier pipeline and output register
   logic signed [32:0]  opa, opb;
   logic signed [65:0]  prod_ff, prod_in;
   logic signed [65:0]  rsum;
   logic signed [49:0]  rnd_ff, rnd_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic signed [31:0]  rsp_data_ff, rsp_data_in;

   logic signed [QUO_W-1:0] k;
   logic                    div_done;

   logic signed [16:0] d1, d2;
   logic [16:0]        ad1, ad2;
   logic signed [31:0] s_q16;
   logic [48:0]        sb_sum;
   logic [DEN_W-1:0]   den_sum;
   logic signed [50:0] innov_diff;
   logic signed [50:0] est_sum;
   logic signed [50:0] f_diff;

   // Gate test on the raw sample history
   assign d1  = 17'(sample_ff) - 17'(last_ff);
   assign d2  = 17'(last_ff) - 17'(prior_ff);
   assign ad1 = d1[16] ? 17'(-d1) : 17'(d1);
   assign ad2 = d2[16] ? 17'(-d2) : 17'(d2);

   assign stat.use_sample = (ad1 <= {1'b0, gl_ff}) || (ad2 > {1'b0, gl_ff});
   assign stat.div_done   = div_done;
   assign stat.out_free   = !rsp_valid_ff || rsp_ready;

   // Select multiplier operands for the current step
   always_comb begin
      case (cmd.op)
         OP_AMU: begin opa = 33'(sg_ff);        opb = 33'(est_ff);         end
         OP_AA:  begin opa = 33'(sg_ff);        opb = 33'(sg_ff);          end
         OP_SB:  begin opa = {2'b00, a2_ff};    opb = {1'b0, var_ff};      end
         OP_CC:  begin opa = 33'(mg_ff);        opb = 33'(mg_ff);          end
         OP_DEN: begin opa = {2'b00, c2_ff};    opb = {1'b0, sb_ff};       end
         OP_NUM: begin opa = {1'b0, sb_ff};     opb = 33'(mg_ff);          end
         OP_CMU: begin opa = 33'(mg_ff);        opb = 33'(mub_ff);         end
         OP_KI:  begin opa = 33'(k);            opb = 33'(innov_ff);       end
         OP_KC:  begin opa = 33'(k);            opb = 33'(mg_ff);          end
         OP_FSB: begin opa = {16'h0000, f_ff};  opb = {1'b0, sb_ff};       end
         OP_OUT: begin opa = 33'(est_ff);       opb = {9'h000, os_ff};     end
         default: begin opa = '0;               opb = '0;                  end
      endcase
   end

   // Multiply, then round to nearest with ties up
   assign prod_in = opa * opb;
   assign rsum    = prod_ff + 66'sd32768;
   assign rnd_in  = rsum[65:16];

   // Post-processing of the rounded product
   assign s_q16      = {sample_ff, 16'h0000};
   assign sb_sum     = rnd_ff[48:0] + {17'h00000, pn_ff};
   assign den_sum    = rnd_ff[DEN_W-1:0] + {16'h0000, mn_ff};
   assign innov_diff = 51'(s_q16) - 51'(rnd_ff);
   assign est_sum    = 51'(mub_ff) + 51'(rnd_ff);
   assign f_diff     = 51'sd65536 - 51'(rnd_ff);

   // Write back the step result, shift history, load config
   always_comb begin
      sg_in        = sg_ff;
      mg_in        = mg_ff;
      pn_in        = pn_ff;
      mn_in        = mn_ff;
      gl_in        = gl_ff;
      os_in        = os_ff;
      sample_in    = sample_ff;
      last_in      = last_ff;
      prior_in     = prior_ff;
      est_in       = est_ff;
      var_in       = var_ff;
      mub_in       = mub_ff;
      a2_in        = a2_ff;
      sb_in        = sb_ff;
      c2_in        = c2_ff;
      den_in       = den_ff;
      num_in       = num_ff;
      innov_in     = innov_ff;
      f_in         = f_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;

      if (csr_write_enable) begin
         case (csr_index)
            CSR_STATE_GAIN:     sg_in = csr_data[23:0];
            CSR_MEASURE_GAIN:   mg_in = csr_data[23:0];
            CSR_PROCESS_NOISE:  pn_in = csr_data[31:0];
            CSR_MEASURE_NOISE:  mn_in = csr_data[31:0];
            CSR_GRADIENT_LIMIT: gl_in = csr_data[15:0];
            CSR_OUTPUT_SCALE:   os_in = csr_data[23:0];
            default: ;
         endcase
      end

      if (cmd.load_sample) begin
         sample_in = req_range_sample;
      end

      if (cmd.shift_hist) begin
         prior_in = last_ff;
         last_in  = sample_ff;
      end

      if (cmd.write_en) begin
         case (cmd.op)
            OP_AMU: mub_in = sat32(51'(rnd_ff));
            OP_AA:  a2_in  = rnd_ff[30:0];
            OP_SB:  sb_in  = (|sb_sum[48:32]) ? 32'hFFFFFFFF : sb_sum[31:0];
            OP_CC:  c2_in  = rnd_ff[30:0];
            OP_DEN: den_in = den_sum;
            OP_NUM: num_in = prod_ff[NUM_W-1:0];
            OP_CMU: innov_in = sat32(innov_diff);
            OP_KI:  est_in = sat32(est_sum);
            OP_KC: begin
               // clamp the variance factor to 0..1.0
               if (f_diff < 0) begin
                  f_in = '0;
               end else if (f_diff > 51'sd65536) begin
                  f_in = 17'd65536;
               end else begin
                  f_in = f_diff[16:0];
               end
            end
            OP_FSB: var_in = rnd_ff[31:0];
            OP_OUT: begin
               rsp_data_in  = sat32(51'(rnd_ff));
               rsp_valid_in = 1'b1;
            end
            default: ;
         endcase
      end
   end

   // Control and architectural state
   always_ff @(posedge clock) begin
      if (reset) begin
         sg_ff        <= RST_STATE_GAIN;
         mg_ff        <= RST_MEASURE_GAIN;
         pn_ff        <= RST_PROCESS_NOISE;
         mn_ff        <= RST_MEASURE_NOISE;
         gl_ff        <= RST_GRADIENT_LIMIT;
         os_ff        <= RST_OUTPUT_SCALE;
         last_ff      <= '0;
         prior_ff     <= '0;
         est_ff       <= '0;
         var_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         sg_ff        <= sg_in;
         mg_ff        <= mg_in;
         pn_ff        <= pn_in;
         mn_ff        <= mn_in;
         gl_ff        <= gl_in;
         os_ff        <= os_in;
         last_ff      <= last_in;
         prior_ff     <= prior_in;
         est_ff       <= est_in;
         var_ff       <= var_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      sample_ff   <= sample_in;
      mub_ff      <= mub_in;
      a2_ff       <= a2_in;
      sb_ff       <= sb_in;
      c2_ff       <= c2_in;
      den_ff      <= den_in;
      num_ff      <= num_in;
      innov_ff    <= innov_in;
      f_ff        <= f_in;
      rsp_data_ff <= rsp_data_in;
      if (cmd.mul_issue) begin
         prod_ff <= prod_in;
      end
      if (cmd.round_en) begin
         rnd_ff <= rnd_in;
      end
   end

   gskrf_div u_div (
      .clock (clock),
      .reset (reset),
      .start (cmd.div_start),
      .num   (num_ff),
      .den   (den_ff),
      .done  (div_done),
      .quo   (k)
   );

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_filtered_range = rsp_data_ff;

endmodule

@@ src/gskrf_ctrl.sv @@
// Controller: sequences the gate test, the multiply steps and the gain division.
module gskrf_ctrl import gskrf_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_ready,
   input  gskrf_stat_type stat,
   output gskrf_cmd_type  cmd
);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_GATE = 3'd1;
   localparam logic [2:0] ST_MUL  = 3'd2;
   localparam logic [2:0] ST_RND  = 3'd3;
   localparam logic [2:0] ST_WB   = 3'd4;
   localparam logic [2:0] ST_DIVS = 3'd5;
   localparam logic [2:0] ST_DIVW = 3'd6;

   logic [2:0]      state_ff, state_in;
   logic [OP_W-1:0] op_ff, op_in;

   assign req_ready = (state_ff == ST_IDLE);

   // Next state and commands
   always_comb begin
      state_in = state_ff;
      op_in    = op_ff;
      cmd      = '0;
      cmd.op   = op_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load_sample = 1'b1;
               state_in        = ST_GATE;
            end
         end
         ST_GATE: begin
            // rejected item goes straight to the output step
            cmd.shift_hist = 1'b1;
            op_in          = stat.use_sample ? OP_AMU : OP_OUT;
            state_in       = ST_MUL;
         end
         ST_MUL: begin
            cmd.mul_issue = 1'b1;
            state_in      = ST_RND;
         end
         ST_RND: begin
            cmd.round_en = 1'b1;
            state_in     = ST_WB;
         end
         ST_WB: begin
            // hold the result until the output register is free
            if (op_ff != OP_OUT || stat.out_free) begin
               cmd.write_en = 1'b1;
               state_in     = ST_MUL;
               case (op_ff)
                  OP_AMU: op_in = OP_AA;
                  OP_AA:  op_in = OP_SB;
                  OP_SB:  op_in = OP_CC;
                  OP_CC:  op_in = OP_DEN;
                  OP_DEN: op_in = OP_NUM;
                  OP_NUM: op_in = OP_CMU;
                  OP_CMU: state_in = ST_DIVS;
                  OP_KI:  op_in = OP_KC;
                  OP_KC:  op_in = OP_FSB;
                  OP_FSB: op_in = OP_OUT;
                  OP_OUT: state_in = ST_IDLE;
                  default: state_in = ST_IDLE;
               endcase
            end
         end
         ST_DIVS: begin
            cmd.div_start = 1'b1;
            state_in      = ST_DIVW;
         end
         ST_DIVW: begin
            if (stat.div_done) begin
               op_in    = OP_KI;
               state_in = ST_MUL;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         op_ff    <= OP_OUT;
      end else begin
         state_ff <= state_in;
         op_ff    <= op_in;
      end
   end

endmodule

@@ src/gated_scalar_kalman_range_filter.sv @@
// Gated scalar Kalman range filter: one range item in, one scaled estimate item out.
// A used sample passes the gate step, 11 multiply steps on one shared 33x33 multiplier
// and the bit-serial gain divider; a rejected sample passes the gate step and the output
// multiply step only. A result still waiting in the output register holds the
// next item's output step. A new item is accepted only once the last one's output is written.
// Reset (synchronous): configuration to defaults, history, estimate and variance to zero.
module gated_scalar_kalman_range_filter import gskrf_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic signed [15:0]    req_range_sample,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic signed [31:0]    rsp_filtered_range,
   input  logic                  csr_write_enable,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   gskrf_cmd_type  cmd;
   gskrf_stat_type stat;

   gskrf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   gskrf_dpath u_dpath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .stat               (stat),
      .req_range_sample   (req_range_sample),
      .rsp_ready          (rsp_ready),
      .rsp_valid          (rsp_valid),
      .rsp_filtered_range (rsp_filtered_range),
      .csr_write_enable   (csr_write_enable),
      .csr_index          (csr_index),
      .csr_data           (csr_data)
   );

endmodule
